[hw/rtl/ipgeo_pkg.sv]
package ipgeo_pkg;

    localparam int IP_W          = 32;
    localparam int FIRST_W       = 17;
    localparam int START_W       = 24;
    localparam int ID_BYTES      = 3;
    localparam int ID_W          = 8 * ID_BYTES;
    localparam int FIRST_DEPTH   = 256;
    localparam int FIRST_AW      = 8;
    localparam int REC_DEPTH_DEF = 65536;
    localparam int CO_DEPTH_DEF  = 4096;

    localparam logic [31:0] SCAN_SPAN = 32'd8;

    // first octets that never resolve
    localparam logic [7:0] OCTET_THIS     = 8'd0;
    localparam logic [7:0] OCTET_PRIVATE  = 8'd10;
    localparam logic [7:0] OCTET_LOOPBACK = 8'd127;

    localparam logic [8:0]  FIRST_LEN_RST  = 9'd224;
    localparam logic [12:0] COARSE_LEN_RST = 13'd0;
    localparam logic [15:0] PART_STEP_RST  = 16'd1;
    localparam logic [16:0] REC_COUNT_RST  = 17'd0;

    localparam logic [1:0] CFG_FIRST_LEN  = 2'd0;
    localparam logic [1:0] CFG_COARSE_LEN = 2'd1;
    localparam logic [1:0] CFG_PART_STEP  = 2'd2;
    localparam logic [1:0] CFG_REC_COUNT  = 2'd3;

    typedef enum logic [1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_FIRST  = 2'd1,
        REQ_COARSE = 2'd2,
        REQ_RECORD = 2'd3
    } req_t;

    typedef enum logic {
        ARITH_DIV = 1'b0,
        ARITH_MUL = 1'b1
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_ctl_t;

endpackage

[hw/rtl/ipgeo_ram.sv]
module ipgeo_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/ipgeo_arith.sv]
// shared bit-serial unit: 17-bit by 16-bit restoring divide, 32-bit by 16-bit multiply
module ipgeo_arith (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ipgeo_pkg::arith_ctl_t ctl,
    input  logic [31:0]           a,
    input  logic [15:0]           b,
    output logic                  done,
    output logic [31:0]           result
);

    logic                 busy_reg;
    logic                 done_reg;
    ipgeo_pkg::arith_op_t op_reg;
    logic [4:0]           cnt_reg;
    logic [31:0]          acc_reg;
    logic [31:0]          sh_reg;
    logic [15:0]          b_reg;
    logic [17:0]          trial;

    assign trial = {1'b0, acc_reg[15:0], sh_reg[16]} - {2'b00, b_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= ipgeo_pkg::ARITH_DIV;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                op_reg   <= ctl.op;
                cnt_reg  <= (ctl.op == ipgeo_pkg::ARITH_DIV) ? 5'd17 : 5'd16;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            acc_reg <= '0;
            b_reg   <= b;
            if (ctl.op == ipgeo_pkg::ARITH_DIV)
            begin
                sh_reg <= {15'd0, a[16:0]};
            end
            else
            begin
                sh_reg <= a;
            end
        end
        else if (busy_reg)
        begin
            if (op_reg == ipgeo_pkg::ARITH_DIV)
            begin
                // quotient bits shift in from the bottom of sh_reg
                if (!trial[17])
                begin
                    acc_reg <= {15'd0, trial[16:0]};
                end
                else
                begin
                    acc_reg <= {15'd0, acc_reg[15:0], sh_reg[16]};
                end
                sh_reg <= {15'd0, sh_reg[15:0], ~trial[17]};
            end
            else
            begin
                if (b_reg[0])
                begin
                    acc_reg <= acc_reg + sh_reg;
                end
                sh_reg <= {sh_reg[30:0], 1'b0};
                b_reg  <= {1'b0, b_reg[15:1]};
            end
        end
    end

    assign done   = done_reg;
    assign result = (op_reg == ipgeo_pkg::ARITH_DIV) ? {15'd0, sh_reg[16:0]} : acc_reg;

endmodule

[hw/rtl/ip_range_geo_lookup.sv]
// IPv4 range to location lookup. A request word carries a kind in s_tuser: a lookup returns
// the 24-bit location id of the range covering the address (0 if none, m_tuser = 1); the three
// write kinds load the first-octet index, the coarse index or a range record and return one
// acknowledgement word with id 0 (m_tuser = 0). One request is handled at a time. A lookup on a
// reserved octet skips the tables; a lookup that uses the coarse index runs two divides and a
// multiply on the shared bit-serial unit, then binary probes and coarse and record scan steps
// (a binary search down to 8 entries, then a linear scan). Table memories have one read port
// each with a registered read, so each binary probe waits for its read data; the record scan
// keeps its next address in flight. Tables are not cleared; read only entries that were written.
module ip_range_geo_lookup #(
    parameter int RECORD_DEPTH = ipgeo_pkg::REC_DEPTH_DEF,
    parameter int COARSE_DEPTH = ipgeo_pkg::CO_DEPTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // ip_addr, entry_index, entry_value, entry_id
    input  logic [1:0]   s_tuser,   // req_type
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [23:0]  m_tdata,   // location_id
    output logic         m_tuser,   // is_lookup
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [16:0]  cfg_data
);

    localparam int REC_AW = $clog2(RECORD_DEPTH);
    localparam int CO_AW  = $clog2(COARSE_DEPTH);

    typedef enum logic [19:0] {
        S_IDLE      = 20'h00001,
        S_CHECK     = 20'h00002,
        S_FB_LO     = 20'h00004,
        S_FB_HI     = 20'h00008,
        S_SPLIT     = 20'h00010,
        S_DIV_LO    = 20'h00020,
        S_DIV_HI    = 20'h00040,
        S_SWAP      = 20'h00080,
        S_PART_TEST = 20'h00100,
        S_PART_CMP  = 20'h00200,
        S_SCAN_RD   = 20'h00400,
        S_SCAN_CMP  = 20'h00800,
        S_MUL       = 20'h01000,
        S_MUL_WAIT  = 20'h02000,
        S_REC_START = 20'h04000,
        S_REC_TEST  = 20'h08000,
        S_REC_CMP   = 20'h10000,
        S_RSCAN_CMP = 20'h20000,
        S_ID_CAP    = 20'h40000,
        S_DONE      = 20'h80000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] ip_reg, ip_next;
    logic [31:0] lo_reg, lo_next;
    logic [31:0] hi_reg, hi_next;
    logic [31:0] mid_reg, mid_next;
    logic [16:0] min_reg, min_next;
    logic [16:0] max_reg, max_next;
    logic [23:0] res_reg, res_next;
    logic        lk_reg, lk_next;

    logic [8:0]  first_len_reg;
    logic [12:0] coarse_len_reg;
    logic [15:0] part_step_reg;
    logic [16:0] rec_count_reg;

    logic        out_valid_reg;
    logic [23:0] out_id_reg;
    logic        out_lk_reg;

    logic        co_oob_reg;
    logic        rec_oob_reg;

    // input word fields
    logic [31:0]     in_ip;
    logic [15:0]     in_idx;
    logic [31:0]     in_val;
    logic [23:0]     in_id;
    ipgeo_pkg::req_t in_req;
    logic            accept;
    logic [31:0]     idx32;

    // table ports
    logic                  fb_we;
    logic [7:0]            fb_raddr;
    logic [16:0]           fb_rdata;
    logic                  co_we;
    logic [31:0]           co_raddr32;
    logic [31:0]           co_rdata;
    logic                  rec_we;
    logic [31:0]           rec_raddr32;
    logic [47:0]           rec_rdata;

    // arithmetic unit
    ipgeo_pkg::arith_ctl_t ar_ctl;
    logic [31:0]           ar_a;
    logic                  ar_done;
    logic [31:0]           ar_result;

    logic [7:0]  fb;
    logic [31:0] ipl;
    logic [15:0] step_eff;
    logic [32:0] mid_sum;
    logic [31:0] mid_w;
    logic [31:0] span;
    logic [31:0] split_diff;
    logic [31:0] co_data;
    logic [31:0] rec_start_w;
    logic [23:0] rec_id_w;
    logic        reserved;
    logic        out_free;
    logic [31:0] lo_c;
    logic [31:0] hi_c;

    assign in_ip  = s_tdata[31:0];
    assign in_idx = s_tdata[47:32];
    assign in_val = s_tdata[79:48];
    assign in_id  = s_tdata[103:80];
    assign in_req = ipgeo_pkg::req_t'(s_tuser);
    assign idx32  = {16'd0, in_idx};

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign fb_we  = accept && (in_req == ipgeo_pkg::REQ_FIRST)
                    && (idx32 < 32'(ipgeo_pkg::FIRST_DEPTH));
    assign co_we  = accept && (in_req == ipgeo_pkg::REQ_COARSE) && (idx32 < 32'(COARSE_DEPTH));
    assign rec_we = accept && (in_req == ipgeo_pkg::REQ_RECORD) && (idx32 < 32'(RECORD_DEPTH));

    ipgeo_ram #(
        .WIDTH (ipgeo_pkg::FIRST_W),
        .DEPTH (ipgeo_pkg::FIRST_DEPTH)
    ) u_first_ram (
        .clk   (clk),
        .we    (fb_we),
        .waddr (in_idx[ipgeo_pkg::FIRST_AW-1:0]),
        .wdata (in_val[16:0]),
        .raddr (fb_raddr),
        .rdata (fb_rdata)
    );

    ipgeo_ram #(
        .WIDTH (32),
        .DEPTH (COARSE_DEPTH)
    ) u_coarse_ram (
        .clk   (clk),
        .we    (co_we),
        .waddr (idx32[CO_AW-1:0]),
        .wdata (in_val),
        .raddr (co_raddr32[CO_AW-1:0]),
        .rdata (co_rdata)
    );

    ipgeo_ram #(
        .WIDTH (ipgeo_pkg::START_W + ipgeo_pkg::ID_W),
        .DEPTH (RECORD_DEPTH)
    ) u_record_ram (
        .clk   (clk),
        .we    (rec_we),
        .waddr (idx32[REC_AW-1:0]),
        .wdata ({in_id, in_val[23:0]}),
        .raddr (rec_raddr32[REC_AW-1:0]),
        .rdata (rec_rdata)
    );

    ipgeo_arith u_arith (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ar_ctl),
        .a      (ar_a),
        .b      (step_eff),
        .done   (ar_done),
        .result (ar_result)
    );

    assign fb          = ip_reg[31:24];
    assign ipl         = {8'd0, ip_reg[23:0]};
    assign step_eff    = (part_step_reg == 16'd0) ? 16'd1 : part_step_reg;
    assign mid_sum     = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_w       = mid_sum[32:1];
    assign span        = hi_reg - lo_reg;
    assign split_diff  = {15'd0, max_reg} - {15'd0, min_reg};
    assign co_data     = co_oob_reg ? 32'd0 : co_rdata;
    assign rec_start_w = rec_oob_reg ? 32'd0 : {8'd0, rec_rdata[23:0]};
    assign rec_id_w    = rec_oob_reg ? 24'd0 : rec_rdata[47:24];
    assign out_free    = !out_valid_reg || m_tready;
    assign reserved    = (fb == ipgeo_pkg::OCTET_THIS) || (fb == ipgeo_pkg::OCTET_PRIVATE)
                         || (fb == ipgeo_pkg::OCTET_LOOPBACK)
                         || ({1'b0, fb} >= first_len_reg) || (ip_reg == 32'hFFFF_FFFF);

    // record bounds of the chosen coarse part
    always_comb
    begin
        lo_c = ar_result;
        if (lo_reg > {19'd0, coarse_len_reg})
        begin
            hi_c = {15'd0, rec_count_reg};
        end
        else
        begin
            hi_c = ar_result + {16'd0, step_eff};
        end
        if (lo_c < {15'd0, min_reg})
        begin
            lo_c = {15'd0, min_reg};
        end
        if (hi_c > {15'd0, max_reg})
        begin
            hi_c = {15'd0, max_reg};
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        ip_next     = ip_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        mid_next    = mid_reg;
        min_next    = min_reg;
        max_next    = max_reg;
        res_next    = res_reg;
        lk_next     = lk_reg;
        fb_raddr    = '0;
        co_raddr32  = '0;
        rec_raddr32 = '0;
        ar_ctl      = '{start: 1'b0, op: ipgeo_pkg::ARITH_DIV};
        ar_a        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    ip_next    = in_ip;
                    res_next   = '0;
                    lk_next    = (in_req == ipgeo_pkg::REQ_LOOKUP);
                    state_next = (in_req == ipgeo_pkg::REQ_LOOKUP) ? S_CHECK : S_DONE;
                end
            end
            S_CHECK:
            begin
                if (reserved)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    fb_raddr   = fb - 8'd1;
                    state_next = S_FB_LO;
                end
            end
            S_FB_LO:
            begin
                min_next   = fb_rdata;
                fb_raddr   = fb;
                state_next = S_FB_HI;
            end
            S_FB_HI:
            begin
                max_next   = fb_rdata;
                state_next = S_SPLIT;
            end
            S_SPLIT:
            begin
                if (split_diff > {16'd0, step_eff})
                begin
                    ar_ctl     = '{start: 1'b1, op: ipgeo_pkg::ARITH_DIV};
                    ar_a       = {15'd0, min_reg};
                    state_next = S_DIV_LO;
                end
                else
                begin
                    lo_next    = {15'd0, min_reg};
                    hi_next    = {15'd0, max_reg};
                    state_next = S_REC_START;
                end
            end
            S_DIV_LO:
            begin
                if (ar_done)
                begin
                    lo_next    = ar_result;
                    ar_ctl     = '{start: 1'b1, op: ipgeo_pkg::ARITH_DIV};
                    ar_a       = {15'd0, max_reg};
                    state_next = S_DIV_HI;
                end
            end
            S_DIV_HI:
            begin
                if (ar_done)
                begin
                    hi_next    = ar_result - 32'd1;
                    state_next = S_SWAP;
                end
            end
            S_SWAP:
            begin
                if (hi_reg < lo_reg)
                begin
                    lo_next = hi_reg;
                    hi_next = lo_reg;
                end
                state_next = S_PART_TEST;
            end
            S_PART_TEST:
            begin
                if (span > ipgeo_pkg::SCAN_SPAN)
                begin
                    mid_next   = mid_w;
                    co_raddr32 = mid_w;
                    state_next = S_PART_CMP;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_PART_CMP:
            begin
                if (ip_reg > co_data)
                begin
                    lo_next = mid_reg;
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = S_PART_TEST;
            end
            S_SCAN_RD:
            begin
                co_raddr32 = lo_reg;
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (ip_reg > co_data)
                begin
                    // steps at most one past the upper bound
                    lo_next    = lo_reg + 32'd1;
                    state_next = (lo_reg < hi_reg) ? S_SCAN_RD : S_MUL;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                ar_ctl     = '{start: 1'b1, op: ipgeo_pkg::ARITH_MUL};
                ar_a       = lo_reg;
                state_next = S_MUL_WAIT;
            end
            S_MUL_WAIT:
            begin
                if (ar_done)
                begin
                    lo_next    = lo_c;
                    hi_next    = hi_c;
                    state_next = S_REC_START;
                end
            end
            S_REC_START:
            begin
                if (hi_reg == lo_reg)
                begin
                    rec_raddr32 = lo_reg;
                    state_next  = S_ID_CAP;
                end
                else if (hi_reg < lo_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_REC_TEST;
                end
            end
            S_REC_TEST:
            begin
                if (span > ipgeo_pkg::SCAN_SPAN)
                begin
                    mid_next    = mid_w;
                    rec_raddr32 = mid_w;
                    state_next  = S_REC_CMP;
                end
                else
                begin
                    rec_raddr32 = lo_reg;
                    state_next  = S_RSCAN_CMP;
                end
            end
            S_REC_CMP:
            begin
                if (ipl > rec_start_w)
                begin
                    lo_next = mid_reg;
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = S_REC_TEST;
            end
            S_RSCAN_CMP:
            begin
                if ((ipl >= rec_start_w) && (lo_reg < hi_reg))
                begin
                    lo_next     = lo_reg + 32'd1;
                    rec_raddr32 = lo_reg + 32'd1;
                end
                else if (lo_reg == 32'd0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    rec_raddr32 = lo_reg - 32'd1;
                    state_next  = S_ID_CAP;
                end
            end
            S_ID_CAP:
            begin
                res_next   = rec_id_w;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            first_len_reg  <= ipgeo_pkg::FIRST_LEN_RST;
            coarse_len_reg <= ipgeo_pkg::COARSE_LEN_RST;
            part_step_reg  <= ipgeo_pkg::PART_STEP_RST;
            rec_count_reg  <= ipgeo_pkg::REC_COUNT_RST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    ipgeo_pkg::CFG_FIRST_LEN:  first_len_reg  <= cfg_data[8:0];
                    ipgeo_pkg::CFG_COARSE_LEN: coarse_len_reg <= cfg_data[12:0];
                    ipgeo_pkg::CFG_PART_STEP:  part_step_reg  <= cfg_data[15:0];
                    ipgeo_pkg::CFG_REC_COUNT:  rec_count_reg  <= cfg_data;
                    default:                   rec_count_reg  <= rec_count_reg;
                endcase
            end
            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ip_reg      <= ip_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        min_reg     <= min_next;
        max_reg     <= max_next;
        res_reg     <= res_next;
        lk_reg      <= lk_next;
        // reads past the table end give zero
        co_oob_reg  <= (co_raddr32 >= 32'(COARSE_DEPTH));
        rec_oob_reg <= (rec_raddr32 >= 32'(RECORD_DEPTH));
        if ((state_reg == S_DONE) && out_free)
        begin
            out_id_reg <= res_reg;
            out_lk_reg <= lk_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_id_reg;
    assign m_tuser  = out_lk_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while a request was in progress");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_DONE) && (!m_tvalid || m_tready)) |=> m_tvalid)
        else $error("finished request did not reach the output register");

    a_part_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PART_TEST) |-> (hi_reg >= lo_reg))
        else $error("coarse search bounds crossed");

endmodule

[dv/ip_range_geo_lookup_tb.sv]
module ip_range_geo_lookup_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ipgeo_pkg::*;

    class geo_scoreboard;
        bit [16:0] first_tab [FIRST_DEPTH];
        bit [31:0] coarse_tab [CO_DEPTH_DEF];
        bit [23:0] rec_start [REC_DEPTH_DEF];
        bit [23:0] rec_id [REC_DEPTH_DEF];
        bit [8:0]  first_len;
        bit [12:0] coarse_len;
        bit [15:0] step_reg;
        bit [16:0] rec_count;
        bit [23:0] want_id [$];
        bit        want_lookup [$];
        int        fails;

        function new();
            first_len  = FIRST_LEN_RST;
            coarse_len = COARSE_LEN_RST;
            step_reg   = PART_STEP_RST;
            rec_count  = REC_COUNT_RST;
            fails      = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [16:0] value);
            case (idx)
                CFG_FIRST_LEN:  first_len  = value[8:0];
                CFG_COARSE_LEN: coarse_len = value[12:0];
                CFG_PART_STEP:  step_reg   = value[15:0];
                default:        rec_count  = value;
            endcase
        endfunction

        function bit [31:0] coarse_at(bit [31:0] i);
            return (i < CO_DEPTH_DEF) ? coarse_tab[i] : 32'd0;
        endfunction

        function bit [31:0] start_at(bit [31:0] i);
            return (i < REC_DEPTH_DEF) ? {8'd0, rec_start[i]} : 32'd0;
        endfunction

        function bit [23:0] id_at(bit [31:0] i);
            return (i < REC_DEPTH_DEF) ? rec_id[i] : 24'd0;
        endfunction

        function bit [31:0] half_sum(bit [31:0] a, bit [31:0] b);
            bit [32:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[32:1];
        endfunction

        function bit [31:0] pick_part(bit [31:0] ip, bit [31:0] lo, bit [31:0] hi);
            bit [31:0] t;
            bit [31:0] mid;
            bit [31:0] was;
            if (hi < lo)
            begin
                t = lo;
                lo = hi;
                hi = t;
            end
            while (hi - lo > SCAN_SPAN)
            begin
                mid = half_sum(lo, hi);
                if (ip > coarse_at(mid))
                    lo = mid;
                else
                    hi = mid;
            end
            while (ip > coarse_at(lo))
            begin
                was = lo;
                lo++;
                if (!(was < hi))
                    break;
            end
            return lo;
        endfunction

        function bit [23:0] pick_record(bit [31:0] ip, bit [31:0] lo, bit [31:0] hi);
            bit [31:0] mid;
            bit [31:0] v;
            if (hi == lo)
                return id_at(lo);
            if (hi < lo)
                return 24'd0;
            ip = ip & 32'h00FF_FFFF;
            while (hi - lo > SCAN_SPAN)
            begin
                mid = half_sum(lo, hi);
                if (ip > start_at(mid))
                    lo = mid;
                else
                    hi = mid;
            end
            v = start_at(lo);
            while (ip >= v && lo < hi)
            begin
                lo++;
                v = start_at(lo);
            end
            return (lo == 0) ? 24'd0 : id_at(lo - 1);
        endfunction

        function bit [23:0] locate(bit [31:0] ip);
            bit [31:0] fb;
            bit [31:0] stp;
            bit [31:0] min_i;
            bit [31:0] max_i;
            bit [31:0] lo;
            bit [31:0] hi;
            bit [31:0] part;
            fb = ip >> 24;
            if (fb == OCTET_THIS || fb == OCTET_PRIVATE || fb == OCTET_LOOPBACK
                || fb >= first_len || ip == 32'hFFFF_FFFF)
                return 24'd0;
            stp = (step_reg != 0) ? step_reg : 32'd1;
            min_i = first_tab[fb - 1];
            max_i = first_tab[fb];
            if (max_i - min_i > stp)
            begin
                part = pick_part(ip, min_i / stp, max_i / stp - 1);
                lo = (part > 0) ? part * stp : 32'd0;
                hi = (part > coarse_len) ? {15'd0, rec_count} : (part + 1) * stp;
                if (lo < min_i)
                    lo = min_i;
                if (hi > max_i)
                    hi = max_i;
            end
            else
            begin
                lo = min_i;
                hi = max_i;
            end
            return pick_record(ip, lo, hi);
        endfunction

        function void note_request(req_t kind, bit [31:0] ip, bit [15:0] idx,
                                   bit [31:0] val, bit [23:0] eid);
            case (kind)
                REQ_LOOKUP:
                begin
                    want_id.push_back(locate(ip));
                    want_lookup.push_back(1'b1);
                    return;
                end
                REQ_FIRST:
                    if (idx < FIRST_DEPTH)
                        first_tab[idx] = val[16:0];
                REQ_COARSE:
                    if (idx < CO_DEPTH_DEF)
                        coarse_tab[idx] = val;
                default:
                begin
                    rec_start[idx] = val[23:0];
                    rec_id[idx]    = eid;
                end
            endcase
            want_id.push_back(24'd0);
            want_lookup.push_back(1'b0);
        endfunction

        function void check_result(bit [23:0] loc, bit lk);
            bit [23:0] e_id;
            bit        e_lk;
            if (want_id.size() == 0)
            begin
                $error("unexpected result word: location_id %h is_lookup %b", loc, lk);
                fails++;
                return;
            end
            e_id = want_id.pop_front();
            e_lk = want_lookup.pop_front();
            if (loc !== e_id)
            begin
                $error("location_id expected %h actual %h", e_id, loc);
                fails++;
            end
            if (lk !== e_lk)
            begin
                $error("is_lookup expected %b actual %b", e_lk, lk);
                fails++;
            end
        endfunction

        function int pending();
            return want_id.size();
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [23:0]  m_tdata;
    logic         m_tuser;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [16:0]  cfg_data;

    geo_scoreboard sb;
    bit  long_hold;
    bit  no_gaps;
    int  quiet_cycles;
    int  rec_n;

    ip_range_geo_lookup dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic send_word(req_t kind, bit [31:0] ip, bit [15:0] idx,
                             bit [31:0] val, bit [23:0] eid);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {eid, val, idx, ip};
        do @(posedge clk); while (!s_tready);
        sb.note_request(kind, ip, idx, val, eid);
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [16:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    // load a consistent table set: monotone first-octet index bounded by rec_n
    task automatic load_tables(int flen, int stp);
        bit [31:0] s;
        bit [31:0] c;
        int        prev;
        int        v;
        int        n_co;
        s = $urandom_range(0, 24'h00_1000);
        for (int r = 0; r <= rec_n; r++)
        begin
            s = s + $urandom_range(0, 32'h0100_0000 / (rec_n + 1) * 2);
            send_word(REQ_RECORD, $urandom, r, {8'($urandom_range(0, 255)), s[23:0]},
                      $urandom_range(0, 24'hFF_FFFF));
        end
        prev = 0;
        for (int b = 0; b < flen; b++)
        begin
            v = (flen > 1) ? rec_n * b / (flen - 1) : 0;
            v = v + $urandom_range(0, 2) - 1;
            if (v < prev)
                v = prev;
            if (v > rec_n)
                v = rec_n;
            prev = v;
            send_word(REQ_FIRST, $urandom, b, {15'($urandom_range(0, 32'h7FFF)), v[16:0]},
                      $urandom);
        end
        n_co = rec_n / ((stp == 0) ? 1 : stp) + 1;
        for (int k = 0; k < n_co; k++)
        begin
            c = k * (32'hFFFF_FFFF / n_co) + $urandom_range(0, 32'h00FF_FFFF);
            send_word(REQ_COARSE, $urandom, k, c, $urandom);
        end
    endtask

    function automatic bit [31:0] pick_addr(int flen);
        bit [31:0] lowp;
        bit [7:0]  fb;
        int        r;
        fb = (flen > 1 && $urandom_range(0, 9) != 0) ? $urandom_range(1, flen - 1)
                                                      : $urandom_range(0, 255);
        r = $urandom_range(0, rec_n);
        case ($urandom_range(0, 2))
            0: lowp = $urandom;
            default: lowp = {8'd0, sb.rec_start[r]} + $urandom_range(0, 2) - 1;
        endcase
        return {fb, lowp[23:0]};
    endfunction

    task automatic run_phase(int flen, int stp, int clen, int rcount, int nrec, int nlook);
        int kind;
        drain();
        write_reg(CFG_FIRST_LEN, flen);
        write_reg(CFG_COARSE_LEN, clen);
        write_reg(CFG_PART_STEP, stp);
        write_reg(CFG_REC_COUNT, rcount);
        rec_n = nrec;
        load_tables(flen, stp);
        for (int i = 0; i < nlook; i++)
        begin
            if (i % 40 == 0)
                no_gaps = ($urandom_range(0, 2) == 0);
            kind = $urandom_range(0, 19);
            if (kind == 0)
                send_word(REQ_RECORD, $urandom, $urandom_range(0, rec_n), $urandom, $urandom);
            else if (kind == 1)
                send_word(REQ_COARSE, $urandom, $urandom_range(CO_DEPTH_DEF, 65535),
                          $urandom, $urandom);
            else if (kind == 2)
                send_word(REQ_FIRST, $urandom, $urandom_range(FIRST_DEPTH, 65535),
                          $urandom, $urandom);
            else
                send_word(REQ_LOOKUP, pick_addr(flen), $urandom, $urandom, $urandom);
        end
        no_gaps = 1'b0;
    endtask

    // receive side, with one long hold-off on request
    initial
    begin
        int w;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            w = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
            if (long_hold)
            begin
                long_hold = 1'b0;
                w = 300;
            end
            @(negedge clk);
            if (w > 0)
            begin
                m_tready <= 1'b0;
                repeat (w) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            sb.check_result(m_tdata, m_tuser);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        sb = new();
        quiet_cycles = 0;
        long_hold = 1'b0;
        no_gaps = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = REQ_LOOKUP;
        cfg_we = 1'b0;
        cfg_index = CFG_FIRST_LEN;
        cfg_data = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reserved octets, all-ones, octet at the length, writes past depth
        run_phase(40, 1, 4096, 65536, 30, 0);
        send_word(REQ_LOOKUP, 32'h00FF_FFFF, 0, 0, 0);
        send_word(REQ_LOOKUP, 32'h0A12_3456, 0, 0, 0);
        send_word(REQ_LOOKUP, 32'h7F00_0001, 0, 0, 0);
        send_word(REQ_LOOKUP, 32'h2800_0000, 0, 0, 0);
        send_word(REQ_LOOKUP, 32'hFFFF_FFFF, 0, 0, 0);
        send_word(REQ_LOOKUP, 32'hFF00_0000, 0, 0, 0);
        send_word(REQ_LOOKUP, 32'h0100_0000, 0, 0, 0);
        send_word(REQ_LOOKUP, 32'h27FF_FFFE, 0, 0, 0);
        send_word(REQ_LOOKUP, {8'd5, sb.rec_start[10]}, 0, 0, 0);
        send_word(REQ_FIRST, 0, 16'hFFFF, 32'hFFFF_FFFF, 24'hFF_FFFF);
        send_word(REQ_FIRST, 0, FIRST_DEPTH, 32'hFFFF_FFFF, 0);
        send_word(REQ_COARSE, 0, CO_DEPTH_DEF, 32'hFFFF_FFFF, 0);
        send_word(REQ_COARSE, 0, 16'hFFFF, 32'hFFFF_FFFF, 0);
        send_word(REQ_RECORD, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 24'hFF_FFFF);
        send_word(REQ_LOOKUP, 32'h1400_0000, 0, 0, 0);

        run_phase(40, 1, 4096, 65536, 30, 40);
        long_hold = 1'b1;
        run_phase(256, 4, 5, 20, 60, 50);
        run_phase(1, 2, 0, 0, 10, 20);
        run_phase(30, 0, 3, 7, 25, 40);
        run_phase(64, 3, 2, 100, 50, 50);
        run_phase(20, 65535, 1, 0, 12, 20);
        run_phase(48, 2, 10, 40, 80, 50);
        drain();
        repeat (200) @(posedge clk);
        if (sb.fails == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
